// ===== rtl/core/ltd_pkg.sv =====
// ----------------------------------------------------------------------------
// ltd_pkg
// Shared widths, register indexes, microcode format and control program of
// the tuner lock tracker.
// ----------------------------------------------------------------------------
package ltd_pkg;

	localparam int TIME_WIDTH_DEF = 32;

	localparam int TICK_W     = 10;
	localparam int FSTEP_W    = 24;
	localparam int STATUS_W   = 7;
	localparam int NOW_W      = 32;
	localparam int DELAY_W    = 12;
	localparam int DRIFT_W    = 32;
	localparam int TOTAL_W    = 16;
	localparam int QUAL_W     = 9;
	localparam int LOST_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP = 1'd1;

	localparam logic [TICK_W-1:0]  TICK_RATE_RST = 10'd100;
	localparam logic [FSTEP_W-1:0] FREQ_STEP_RST = 24'd1000;

	localparam int LOCK_BIT     = 4;
	localparam int TIMEDOUT_BIT = 5;
	localparam logic [STATUS_W-1:0] KEEP_MASK = 7'h5F;

	// quality filter: q = (q*220 + lock*36*256) / 256
	localparam int QUAL_DECAY  = 220;
	localparam int LOCK_BONUS  = 36 * 256;
	localparam int QUAL_SHIFT  = 8;
	localparam int QUAL_SUM_W  = 18;
	localparam int QUAL_MID    = 128;
	// (q-128)^2 * rate / (128*128)
	localparam int DELAY_SHIFT = 14;
	localparam int DRIFT_PER_W = 5;

	// reciprocal multiplies for rate/20 and rate/5, exact over 10-bit rates
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP20     = 3277;
	localparam int RECIP5      = 13108;

	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam int UPC_W = 4;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_QUAL,
		OP_DELAY,
		OP_LOST,
		OP_DRIFT,
		OP_STATUS,
		OP_RETUNE,
		OP_EMIT
	} ltd_op_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_Q220,
		MUL_DD,
		MUL_DDTR,
		MUL_DRIFT
	} ltd_mul_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_ALWAYS,
		J_IF_RETUNE,
		J_IF_LOCKED,
		J_HOLD_IN,
		J_HOLD_OUT
	} ltd_jump_t;

	typedef struct packed {
		ltd_op_t            op;
		ltd_mul_t           mul;
		ltd_jump_t          jump;
		logic [UPC_W-1:0]   target;
	} ltd_ucode_t;

	typedef struct packed {
		ltd_op_t  op;
		ltd_mul_t mul;
	} ltd_ctrl_t;

	typedef struct packed {
		logic retune;
		logic locked;
		logic out_free;
	} ltd_flags_t;

	localparam logic [UPC_W-1:0] PC_WAIT   = 4'd0;
	localparam logic [UPC_W-1:0] PC_MQ     = 4'd1;
	localparam logic [UPC_W-1:0] PC_QUAL   = 4'd2;
	localparam logic [UPC_W-1:0] PC_MDD    = 4'd3;
	localparam logic [UPC_W-1:0] PC_MDDTR  = 4'd4;
	localparam logic [UPC_W-1:0] PC_DELAY  = 4'd5;
	localparam logic [UPC_W-1:0] PC_LOST   = 4'd6;
	localparam logic [UPC_W-1:0] PC_MDRIFT = 4'd7;
	localparam logic [UPC_W-1:0] PC_DRIFT  = 4'd8;
	localparam logic [UPC_W-1:0] PC_STATUS = 4'd9;
	localparam logic [UPC_W-1:0] PC_RETUNE = 4'd10;
	localparam logic [UPC_W-1:0] PC_EMIT   = 4'd11;

	function automatic ltd_ucode_t ucode(input logic [UPC_W-1:0] pc);
		ltd_ucode_t w;
		w = '{op: OP_NONE, mul: MUL_NONE, jump: J_ALWAYS, target: PC_WAIT};
		case (pc)
			PC_WAIT:   w = '{op: OP_LOAD,   mul: MUL_NONE,  jump: J_HOLD_IN,   target: PC_WAIT};
			PC_MQ:     w = '{op: OP_NONE,   mul: MUL_Q220,  jump: J_IF_RETUNE, target: PC_RETUNE};
			PC_QUAL:   w = '{op: OP_QUAL,   mul: MUL_NONE,  jump: J_NEXT,      target: PC_WAIT};
			PC_MDD:    w = '{op: OP_NONE,   mul: MUL_DD,    jump: J_NEXT,      target: PC_WAIT};
			PC_MDDTR:  w = '{op: OP_NONE,   mul: MUL_DDTR,  jump: J_NEXT,      target: PC_WAIT};
			PC_DELAY:  w = '{op: OP_DELAY,  mul: MUL_NONE,  jump: J_IF_LOCKED, target: PC_STATUS};
			PC_LOST:   w = '{op: OP_LOST,   mul: MUL_NONE,  jump: J_NEXT,      target: PC_WAIT};
			PC_MDRIFT: w = '{op: OP_NONE,   mul: MUL_DRIFT, jump: J_NEXT,      target: PC_WAIT};
			PC_DRIFT:  w = '{op: OP_DRIFT,  mul: MUL_NONE,  jump: J_NEXT,      target: PC_WAIT};
			PC_STATUS: w = '{op: OP_STATUS, mul: MUL_NONE,  jump: J_ALWAYS,    target: PC_EMIT};
			PC_RETUNE: w = '{op: OP_RETUNE, mul: MUL_NONE,  jump: J_NEXT,      target: PC_WAIT};
			PC_EMIT:   w = '{op: OP_EMIT,   mul: MUL_NONE,  jump: J_HOLD_OUT,  target: PC_WAIT};
			default:   w = '{op: OP_NONE,   mul: MUL_NONE,  jump: J_ALWAYS,    target: PC_WAIT};
		endcase
		return w;
	endfunction

	function automatic logic [TICK_W-1:0] tick_div20(input logic [TICK_W-1:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'(RECIP20);
		return TICK_W'(p >> RECIP_SHIFT);
	endfunction

	function automatic logic [TICK_W-1:0] tick_div5(input logic [TICK_W-1:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'(RECIP5);
		return TICK_W'(p >> RECIP_SHIFT);
	endfunction

endpackage

// ===== rtl/core/ltd_if.sv =====
// ----------------------------------------------------------------------------
// ltd interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface ltd_item_if import ltd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                command;
	logic [STATUS_W-1:0] status_bits;
	logic [NOW_W-1:0]    now_ticks;

	modport source (output valid, command, status_bits, now_ticks, input ready);
	modport sink   (input valid, command, status_bits, now_ticks, output ready);
endinterface

interface ltd_result_if import ltd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [DELAY_W-1:0]        poll_delay;
	logic signed [DRIFT_W-1:0] drift_offset;
	logic                      retune_issued;
	logic [STATUS_W-1:0]       status_out;
	logic                      event_valid;
	logic [TOTAL_W-1:0]        timeout_total;

	modport source (output valid, poll_delay, drift_offset, retune_issued, status_out,
		event_valid, timeout_total, input ready);
	modport sink   (input valid, poll_delay, drift_offset, retune_issued, status_out,
		event_valid, timeout_total, output ready);
endinterface

interface ltd_cfg_if import ltd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ltd_seq.sv =====
// ----------------------------------------------------------------------------
// ltd_seq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module ltd_seq import ltd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  ltd_flags_t flags,
	output logic       in_ready,
	output ltd_ctrl_t  ctrl
);

	logic [UPC_W-1:0] step_q;
	logic [UPC_W-1:0] step_nxt;
	ltd_ucode_t       uw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= PC_WAIT;
		end else begin
			step_q <= step_nxt;
		end
	end

	always_comb begin
		uw       = ucode(step_q);
		step_nxt = step_q + 1'b1;
		ctrl.op  = uw.op;
		ctrl.mul = uw.mul;
		case (uw.jump)
			J_NEXT: begin
				step_nxt = step_q + 1'b1;
			end
			J_ALWAYS: begin
				step_nxt = uw.target;
			end
			J_IF_RETUNE: begin
				if (flags.retune) step_nxt = uw.target;
			end
			J_IF_LOCKED: begin
				if (flags.locked) step_nxt = uw.target;
			end
			J_HOLD_IN: begin
				// hold until a request arrives
				if (!in_valid) begin
					step_nxt = step_q;
					ctrl.op  = OP_NONE;
				end
			end
			J_HOLD_OUT: begin
				// hold while the previous result is still unclaimed
				if (flags.out_free) begin
					step_nxt = uw.target;
				end else begin
					step_nxt = step_q;
					ctrl.op  = OP_NONE;
				end
			end
			default: begin
				step_nxt = PC_WAIT;
			end
		endcase
	end

	assign in_ready = (uw.jump == J_HOLD_IN);

endmodule

// ===== rtl/core/ltd_dp.sv =====
// ----------------------------------------------------------------------------
// ltd_dp
// Tracker state, shared multiplier, settings and result register.
// ----------------------------------------------------------------------------
module ltd_dp import ltd_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ltd_ctrl_t                 ctrl,
	output ltd_flags_t                flags,
	input  logic                      command,
	input  logic [STATUS_W-1:0]       status_bits,
	input  logic [NOW_W-1:0]          now_ticks,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [DELAY_W-1:0]        poll_delay,
	output logic signed [DRIFT_W-1:0] drift_offset,
	output logic                      retune_issued,
	output logic [STATUS_W-1:0]       status_out,
	output logic                      event_valid,
	output logic [TOTAL_W-1:0]        timeout_total
);

	// settings
	logic [TICK_W-1:0]  tick_rate_q;
	logic [FSTEP_W-1:0] freq_step_q;

	// request latch
	logic                cmd_q;
	logic [STATUS_W-1:0] sbits_q;
	logic [NOW_W-1:0]    now_q;

	// tracker state
	logic [QUAL_W-1:0]     qual_q;
	logic [LOST_W-1:0]     lost_q;
	logic [DRIFT_W-1:0]    drift_q;
	logic [TOTAL_W-1:0]    tocnt_q;
	logic [STATUS_W-1:0]   status_q;
	logic [TIME_WIDTH-1:0] lost_time_q;

	// work registers
	logic [PROD_W-1:0]  prod_q;
	logic [DELAY_W-1:0] delay_q;
	logic               retune_q;
	logic               event_q;
	logic               out_valid_q;

	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]    mul_b;
	logic [QUAL_W-1:0]     qual_dist;
	logic [LOST_W:0]       half_j;
	logic [QUAL_SUM_W-1:0] qual_sum;
	logic [TIME_WIDTH-1:0] now_tw;
	logic [TIME_WIDTH-1:0] since_lost;
	logic                  timed_out;
	logic [STATUS_W-1:0]   next_status;
	logic                  locked;
	logic                  out_free;

	assign locked   = sbits_q[LOCK_BIT];
	assign out_free = !out_valid_q || out_ready;
	assign flags    = '{retune: cmd_q, locked: locked, out_free: out_free};

	assign qual_dist = (qual_q >= QUAL_W'(QUAL_MID)) ? qual_q - QUAL_W'(QUAL_MID)
		: QUAL_W'(QUAL_MID) - qual_q;
	assign half_j = ({1'b0, lost_q} + 1'b1) >> 1;

	always_comb begin
		case (ctrl.mul)
			MUL_Q220: begin
				mul_a = MUL_A_W'(qual_q);
				mul_b = MUL_B_W'(QUAL_DECAY);
			end
			MUL_DD: begin
				mul_a = MUL_A_W'(qual_dist);
				mul_b = MUL_B_W'(qual_dist);
			end
			MUL_DDTR: begin
				mul_a = MUL_A_W'(tick_rate_q);
				mul_b = prod_q[MUL_B_W-1:0];
			end
			MUL_DRIFT: begin
				mul_a = freq_step_q;
				mul_b = MUL_B_W'(half_j);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign qual_sum = QUAL_SUM_W'(prod_q) + (locked ? QUAL_SUM_W'(LOCK_BONUS) : '0);

	// elapsed ticks since lock was lost, modulo the time width
	assign now_tw     = TIME_WIDTH'(now_q);
	assign since_lost = now_tw - lost_time_q;
	assign timed_out  = !locked && (since_lost > TIME_WIDTH'({tick_rate_q, 1'b0}));

	always_comb begin
		next_status               = sbits_q;
		next_status[TIMEDOUT_BIT] = timed_out;
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul != MUL_NONE) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (ctrl.op == OP_LOAD) begin
			cmd_q   <= command;
			sbits_q <= status_bits;
			now_q   <= now_ticks;
		end
		if (ctrl.op == OP_EMIT) begin
			poll_delay    <= delay_q;
			drift_offset  <= drift_q;
			retune_issued <= retune_q;
			status_out    <= status_q;
			event_valid   <= event_q;
			timeout_total <= tocnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RST;
			freq_step_q <= FREQ_STEP_RST;
			qual_q      <= '0;
			lost_q      <= '0;
			drift_q     <= '0;
			tocnt_q     <= '0;
			status_q    <= '0;
			lost_time_q <= '0;
			delay_q     <= '0;
			retune_q    <= 1'b0;
			event_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TICK_RATE: tick_rate_q <= cfg_data[TICK_W-1:0];
					REG_FREQ_STEP: freq_step_q <= cfg_data[FSTEP_W-1:0];
					default: begin
					end
				endcase
			end

			if (ctrl.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (ctrl.op)
				OP_LOAD: begin
					retune_q <= 1'b0;
					event_q  <= 1'b0;
				end
				OP_QUAL: begin
					qual_q <= qual_sum[QUAL_SHIFT +: QUAL_W];
				end
				OP_DELAY: begin
					delay_q <= DELAY_W'(tick_div20(tick_rate_q))
						+ prod_q[DELAY_SHIFT +: DELAY_W];
				end
				OP_LOST: begin
					lost_q   <= lost_q + 1'b1;
					delay_q  <= DELAY_W'(tick_div5(tick_rate_q));
					retune_q <= 1'b1;
				end
				OP_DRIFT: begin
					// zigzag: odd counts step out, even counts mirror, restart each period
					if (lost_q[0]) begin
						drift_q <= drift_q + prod_q[DRIFT_W-1:0];
					end else if (lost_q[DRIFT_PER_W-1:0] == '0) begin
						drift_q <= '0;
					end else begin
						drift_q <= '0 - drift_q;
					end
				end
				OP_STATUS: begin
					if (locked) begin
						lost_q  <= '0;
						tocnt_q <= '0;
					end else if (timed_out && !status_q[TIMEDOUT_BIT]
							&& tocnt_q != '1) begin
						tocnt_q <= tocnt_q + 1'b1;
					end
					if (next_status != status_q) begin
						status_q <= next_status;
						event_q  <= 1'b1;
						if (status_q[LOCK_BIT] && !next_status[LOCK_BIT]) begin
							lost_time_q <= now_tw;
						end
					end
				end
				OP_RETUNE: begin
					tocnt_q     <= '0;
					lost_q      <= '0;
					drift_q     <= '0;
					lost_time_q <= now_tw;
					delay_q     <= '0;
					if ((status_q & KEEP_MASK) != '0) begin
						status_q <= '0;
						event_q  <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/tuner_lock_tracker_with_drift_scan.sv =====
// ----------------------------------------------------------------------------
// tuner_lock_tracker_with_drift_scan
// Receiver lock supervisor with quality-driven poll delay and drift scan.
// ----------------------------------------------------------------------------
// One request at a time is run by a 12-step control program over a datapath
// with one shared 24x18 multiplier. A poll without lock runs more steps than
// a locked poll (lost count, drift multiply and drift step), and a retune
// skips the quality, delay and drift steps. The multiplier passes run in
// series (quality filter, squared distance, scaling by the tick rate, drift
// step). The result sits in an output register; the next request is taken
// once the program returns to its wait step, which happens as soon as the
// output register is free. Register writes are accepted in any cycle and
// should be issued only while idle.
module tuner_lock_tracker_with_drift_scan import ltd_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input logic            clk,
	input logic            arst_n,
	ltd_item_if.sink       item,
	ltd_result_if.source   result,
	ltd_cfg_if.sink        cfg
);

	ltd_ctrl_t  ctrl;
	ltd_flags_t flags;

	assign cfg.ready = 1'b1;

	ltd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.flags    (flags),
		.in_ready (item.ready),
		.ctrl     (ctrl)
	);

	ltd_dp #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.flags         (flags),
		.command       (item.command),
		.status_bits   (item.status_bits),
		.now_ticks     (item.now_ticks),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.poll_delay    (result.poll_delay),
		.drift_offset  (result.drift_offset),
		.retune_issued (result.retune_issued),
		.status_out    (result.status_out),
		.event_valid   (result.event_valid),
		.timeout_total (result.timeout_total)
	);

endmodule

// ===== rtl/core/ltd_chk.sv =====
// ----------------------------------------------------------------------------
// ltd_chk
// Port-level checks on the lock tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ltd_chk import ltd_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [DELAY_W-1:0]  poll_delay,
	input logic                retune_issued,
	input logic [STATUS_W-1:0] status_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(poll_delay)
			&& $stable(status_out))
		else $error("result changed while stalled");

	// one request at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in flight");

	// timed out is only ever reported without lock
	a_timeout_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_out[TIMEDOUT_BIT] |-> !status_out[LOCK_BIT])
		else $error("timed out reported with lock");

	// recovery retune only on a poll that saw no lock
	a_retune_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && retune_issued |-> !status_out[LOCK_BIT])
		else $error("recovery retune with lock");

endmodule

bind tuner_lock_tracker_with_drift_scan ltd_chk u_ltd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.poll_delay    (result.poll_delay),
	.retune_issued (result.retune_issued),
	.status_out    (result.status_out)
);

// ===== tb/tb_tuner_lock_tracker_with_drift_scan.sv =====
// ----------------------------------------------------------------------------
// tb_tuner_lock_tracker_with_drift_scan
// Self-checking bench for the lock supervisor. A short table of requests
// covers reset state, lock loss and recovery, the timeout threshold, wrapped
// tick counters, retunes with and without a status event, and the extreme
// tick rates and step sizes. Random phases follow under several register
// settings, with locked runs, lost-lock runs, retunes and noise. A closing
// train of lost polls moves in and out of the timed-out state back to back.
// Every result is checked against the table's expected value where given,
// else against a predictor of the block.
module tb_tuner_lock_tracker_with_drift_scan;
	import ltd_pkg::*;

	localparam logic CMD_POLL   = 1'b0;
	localparam logic CMD_RETUNE = 1'b1;

	localparam int PHASE_ITEMS = 90;
	localparam int TIMEOUT_SOAK_POLLS = 40;
	localparam int CYCLE_LIMIT = 200_000;

	typedef struct packed {
		logic [DELAY_W-1:0]        delay;
		logic signed [DRIFT_W-1:0] drift;
		logic                      retune;
		logic [STATUS_W-1:0]       status;
		logic                      changed;
		logic [TOTAL_W-1:0]        total;
	} outcome_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {RUN_LOCKED, RUN_LOST, RUN_RETUNE, RUN_NOISE} run_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic                  cmd;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [STATUS_W-1:0]   sbits;
		logic [31:0]           arg;
		logic                  known;
		outcome_t              want;
	} step_row_t;

	localparam outcome_t NO_RESULT = '0;

	logic clk;
	logic arst_n;

	ltd_item_if   item_ch ();
	ltd_result_if res_ch ();
	ltd_cfg_if    cfg_ch ();

	tuner_lock_tracker_with_drift_scan dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// supervisor state and registers as the bench sees them
	logic [QUAL_W-1:0]   lock_q;
	logic [LOST_W-1:0]   lost_polls;
	logic [DRIFT_W-1:0]  drift_acc;
	logic [TOTAL_W-1:0]  timeouts;
	logic [STATUS_W-1:0] status_now;
	logic [NOW_W-1:0]    lost_at;
	logic [TICK_W-1:0]   tick_rate_cfg;
	logic [FSTEP_W-1:0]  freq_step_cfg;

	outcome_t pending_results [$];
	int errors;
	bit gaps_on;

	run_kind_t run_now;
	int unsigned run_left;
	logic [STATUS_W-1:0] run_bits;
	logic [NOW_W-1:0] now_clk;

	step_row_t directed_rows [25] = '{
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd0, 1'b1,
			'{12'd20, 32'sd1000, 1'b1, 7'h00, 1'b0, 16'd0}},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd300, 1'b1,
			'{12'd20, -32'sd1000, 1'b1, 7'h20, 1'b1, 16'd1}},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h7f, 32'd301, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h10, 32'd302, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h10, 32'hffff_ffff, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h6f, 32'd1000, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd1200, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd1201, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_RETUNE, REG_TICK_RATE, 7'h7f, 32'd1202, 1'b1,
			'{12'd0, 32'sd0, 1'b0, 7'h20, 1'b0, 16'd0}},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h4f, 32'd1202, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_RETUNE, REG_TICK_RATE, 7'h00, 32'hffff_fff0, 1'b1,
			'{12'd0, 32'sd0, 1'b0, 7'h00, 1'b1, 16'd0}},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'h10, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'hc0, 1'b0, NO_RESULT},
		'{ROW_CFG, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd0, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_RETUNE, REG_TICK_RATE, 7'h00, 32'd7, 1'b1,
			'{12'd0, 32'sd0, 1'b0, 7'h20, 1'b0, 16'd0}},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd7, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd8, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h10, 32'd8, 1'b0, NO_RESULT},
		'{ROW_CFG, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd1023, 1'b0, NO_RESULT},
		'{ROW_CFG, CMD_POLL, REG_FREQ_STEP, 7'h00, 32'hff_ffff, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h10, 32'd9, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd10, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd2056, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_POLL, REG_TICK_RATE, 7'h00, 32'd2057, 1'b0, NO_RESULT},
		'{ROW_REQ, CMD_RETUNE, REG_TICK_RATE, 7'h3f, 32'd2058, 1'b0, NO_RESULT}
	};

	// Advance the supervisor by one request and return its result.
	function automatic outcome_t supervise(input logic cmd, input logic [STATUS_W-1:0] sb,
			input logic [NOW_W-1:0] now);
		outcome_t o;
		logic [STATUS_W-1:0] s;
		logic [63:0] q;
		logic [63:0] d;
		logic [63:0] dly;
		logic [31:0] lost_no;
		logic [NOW_W-1:0] since;
		o = '0;
		if (cmd == CMD_RETUNE) begin
			timeouts = '0;
			lost_polls = '0;
			lost_at = now;
			drift_acc = '0;
			// timed-out alone does not count as a status to clear
			if ((status_now & KEEP_MASK) != '0) begin
				status_now = '0;
				o.changed = 1'b1;
			end
		end else begin
			q = (64'(lock_q) * QUAL_DECAY + (sb[LOCK_BIT] ? 64'(LOCK_BONUS) : 64'd0)) / 256;
			lock_q = q[QUAL_W-1:0];
			d = (lock_q >= QUAL_MID) ? 64'(lock_q) - QUAL_MID : QUAL_MID - 64'(lock_q);
			dly = 64'(tick_rate_cfg) / 20 + d * d * 64'(tick_rate_cfg) / (128 * 128);
			s = sb & KEEP_MASK;
			if (sb[LOCK_BIT]) begin
				timeouts = '0;
				lost_polls = '0;
			end else begin
				lost_polls = lost_polls + 1'b1;
				lost_no = 32'(lost_polls);
				// restart the zigzag every 32 lost polls
				if (lost_no[4:0] == 5'd0)
					drift_acc = '0;
				if (lost_no[0])
					drift_acc = drift_acc + 32'(freq_step_cfg) * ((lost_no + 32'd1) / 32'd2);
				else
					drift_acc = -drift_acc;
				o.retune = 1'b1;
				dly = 64'(tick_rate_cfg) / 5;
				since = now - lost_at;
				if (64'(since) > 2 * 64'(tick_rate_cfg)) begin
					s[TIMEDOUT_BIT] = 1'b1;
					if (!status_now[TIMEDOUT_BIT] && timeouts != '1)
						timeouts = timeouts + 1'b1;
				end
			end
			if (s != status_now) begin
				if (status_now[LOCK_BIT] && !s[LOCK_BIT])
					lost_at = now;
				status_now = s;
				o.changed = 1'b1;
			end
			o.delay = dly[DELAY_W-1:0];
		end
		o.drift = drift_acc;
		o.status = status_now;
		o.total = timeouts;
		return o;
	endfunction

	task automatic compare_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	task automatic send_request(input logic cmd, input logic [STATUS_W-1:0] sb,
			input logic [NOW_W-1:0] now, input logic known, input outcome_t want);
		outcome_t predicted;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.status_bits <= sb;
		item_ch.now_ticks <= now;
		do @(posedge clk); while (!item_ch.ready);
		predicted = supervise(cmd, sb, now);
		pending_results.push_back(known ? want : predicted);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_TICK_RATE)
			tick_rate_cfg = TICK_W'(value);
		else
			freq_step_cfg = FSTEP_W'(value);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Drop the request line and wait until every result is back.
	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic random_item();
		logic [STATUS_W-1:0] sb;
		logic cmd;
		int unsigned roll;
		if (run_left == 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				run_now = RUN_LOCKED;
				run_left = $urandom_range(1, 20);
			end else if (roll < 85) begin
				run_now = RUN_LOST;
				run_left = $urandom_range(1, 40);
			end else if (roll < 93) begin
				run_now = RUN_RETUNE;
				run_left = 1;
			end else begin
				run_now = RUN_NOISE;
				run_left = $urandom_range(1, 5);
			end
			run_bits = STATUS_W'($urandom);
		end
		run_left--;
		// mostly move forward in time; sometimes jump anywhere or step back
		roll = $urandom_range(0, 99);
		if (roll < 4)
			now_clk = $urandom;
		else if (roll < 7)
			now_clk = now_clk - $urandom_range(0, 3 * tick_rate_cfg);
		else
			now_clk = now_clk + $urandom_range(0, tick_rate_cfg + 8);
		sb = ($urandom_range(0, 4) == 0) ? STATUS_W'($urandom) : run_bits;
		cmd = CMD_POLL;
		case (run_now)
			RUN_LOCKED: sb[LOCK_BIT] = 1'b1;
			RUN_LOST:   sb[LOCK_BIT] = 1'b0;
			RUN_RETUNE: cmd = CMD_RETUNE;
			default:    cmd = 1'($urandom);
		endcase
		send_request(cmd, sb, now_clk, 1'b0, NO_RESULT);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int unsigned hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && gaps_on && $urandom_range(0, 3) == 0)
				hold_left = $urandom_range(1, 3);
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding", $time);
			end else begin
				want = pending_results.pop_front();
				compare_field("poll_delay", want.delay, res_ch.poll_delay);
				compare_field("drift_offset", want.drift, res_ch.drift_offset);
				compare_field("retune_issued", want.retune, res_ch.retune_issued);
				compare_field("status_out", want.status, res_ch.status_out);
				compare_field("event_valid", want.changed, res_ch.event_valid);
				compare_field("timeout_total", want.total, res_ch.timeout_total);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_tuner_lock_tracker_with_drift_scan: FAIL");
		$finish;
	end

	initial begin
		logic [31:0] tick_plan [6];
		logic [31:0] step_plan [6];
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_POLL;
		item_ch.status_bits = '0;
		item_ch.now_ticks = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TICK_RATE;
		cfg_ch.data = '0;
		errors = 0;
		gaps_on = 1'b1;
		run_now = RUN_LOCKED;
		run_left = 0;
		run_bits = '0;
		now_clk = '0;
		lock_q = '0;
		lost_polls = '0;
		drift_acc = '0;
		timeouts = '0;
		status_now = '0;
		lost_at = '0;
		tick_rate_cfg = TICK_RATE_RST;
		freq_step_cfg = FREQ_STEP_RST;
		tick_plan = '{1, 100, 20, 1023, 0, $urandom_range(1, 1023)};
		step_plan = '{1, 1000, 0, 32'hff_ffff, $urandom, $urandom};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				settle();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].arg);
			end else begin
				send_request(directed_rows[i].cmd, directed_rows[i].sbits,
					directed_rows[i].arg, directed_rows[i].known, directed_rows[i].want);
			end
		end

		for (int p = 0; p < 6; p++) begin
			settle();
			write_reg(REG_TICK_RATE, tick_plan[p]);
			write_reg(REG_FREQ_STEP, step_plan[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// switch idling on and off in stretches; none in the last phase
				if (n % 25 == 0)
					gaps_on = (p != 5) && ($urandom_range(0, 2) != 0);
				random_item();
			end
		end

		// Alternate no-timeout and timeout polls after a retune at tick zero:
		// each pair enters the timed-out state once.
		settle();
		gaps_on = 1'b0;
		write_reg(REG_TICK_RATE, 32'd100);
		write_reg(REG_FREQ_STEP, $urandom);
		send_request(CMD_RETUNE, '0, '0, 1'b0, NO_RESULT);
		for (int k = 0; k < TIMEOUT_SOAK_POLLS; k++)
			send_request(CMD_POLL, '0, (k % 2 == 1) ? '1 : '0, 1'b0, NO_RESULT);

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_tuner_lock_tracker_with_drift_scan: PASS");
		else
			$display("tb_tuner_lock_tracker_with_drift_scan: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ltd_pkg.sv
rtl/core/ltd_if.sv
rtl/core/ltd_seq.sv
rtl/core/ltd_dp.sv
rtl/core/tuner_lock_tracker_with_drift_scan.sv
rtl/core/ltd_chk.sv
tb/tb_tuner_lock_tracker_with_drift_scan.sv
